// File: rtl/gdg_pkg.sv
// Shared types and constants for the grid distance-to-goal block.
`timescale 1ns / 1ps

package gdg_pkg;

    // Fixed field widths
    localparam int CLASS_W = 5;
    localparam int COORD_W = 10;
    localparam int FW_W    = 11;
    localparam int MASK_W  = 32;
    localparam int DIST_W  = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Distance saturation value and frame width after reset
    localparam logic [DIST_W-1:0] DIST_MAX = 15'h7FFF;
    localparam logic [FW_W-1:0]   FW_RESET = 11'd1024;

    // Scale of the squared distance: 4 fraction bits in the root
    localparam int Q_SHIFT = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OBST_MASK   = 3'd0,
        CFG_FRAME_WIDTH = 3'd1,
        CFG_EGO_LEFT    = 3'd2,
        CFG_EGO_RIGHT   = 3'd3,
        CFG_EGO_TOP     = 3'd4,
        CFG_EGO_BOTTOM  = 3'd5,
        CFG_GOAL_COL    = 3'd6,
        CFG_GOAL_ROW    = 3'd7
    } t_cfg_idx;

    // Configuration register file contents
    typedef struct packed {
        logic [MASK_W-1:0]  obstacle_class_mask;
        logic [FW_W-1:0]    frame_width;
        logic [COORD_W-1:0] ego_left;
        logic [COORD_W-1:0] ego_right;
        logic [COORD_W-1:0] ego_top;
        logic [COORD_W-1:0] ego_bottom;
        logic [COORD_W-1:0] goal_col;
        logic [COORD_W-1:0] goal_row;
    } t_cfg;

endpackage

// File: rtl/grid_distance_to_goal.sv
// Top level of the grid distance-to-goal map generator.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_valid/o_ready) carries one grid cell per transfer in raster
//   order: i_frame_start marks column 0, row 0; i_cell_class is its class code.
//   Output channel (o_valid/i_ready) returns one result per cell, in order:
//   o_distance_q4 (distance to the goal, 4 fraction bits, truncated) or
//   o_blocked for an obstacle cell outside the ego box (distance then 0).
//   Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Timing:
//   Stages, with R = root width (15 at default sizes):
//   three front stages, one root cell per result bit, one output register.
//   Throughput is one cell per cycle; every stage is an elastic register, so
//   a stalled receiver only backs up the chain once all bubbles are filled.
// Reset:
//   Synchronous, active low. Clears the position counters, all valid bits and
//   the registers (frame width returns to 1024, all others to zero).

module grid_distance_to_goal
    import gdg_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int NUM_CLASSES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_frame_start,
    input  logic [CLASS_W-1:0]    i_cell_class,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DIST_W-1:0]     o_distance_q4,
    output logic                  o_blocked
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int DW     = (CW > RW) ? ((CW > COORD_W) ? CW : COORD_W)
                                      : ((RW > COORD_W) ? RW : COORD_W);
    localparam int ROOT_W = DW + 5;
    localparam int VW     = 2 * ROOT_W;

    t_cfg r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{frame_width: FW_RESET, default: '0};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OBST_MASK:   r_cfg.obstacle_class_mask <= i_cfg_data[MASK_W-1:0];
                CFG_FRAME_WIDTH: r_cfg.frame_width <= i_cfg_data[FW_W-1:0];
                CFG_EGO_LEFT:    r_cfg.ego_left    <= i_cfg_data[COORD_W-1:0];
                CFG_EGO_RIGHT:   r_cfg.ego_right   <= i_cfg_data[COORD_W-1:0];
                CFG_EGO_TOP:     r_cfg.ego_top     <= i_cfg_data[COORD_W-1:0];
                CFG_EGO_BOTTOM:  r_cfg.ego_bottom  <= i_cfg_data[COORD_W-1:0];
                CFG_GOAL_COL:    r_cfg.goal_col    <= i_cfg_data[COORD_W-1:0];
                CFG_GOAL_ROW:    r_cfg.goal_row    <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Links between chain cells; link 0 comes from the front end
    logic              c_valid [0:ROOT_W];
    logic              c_rdy   [0:ROOT_W];
    logic              c_blk   [0:ROOT_W];
    logic [VW-1:0]     c_v     [0:ROOT_W];
    logic [ROOT_W:0]   c_rem   [0:ROOT_W];
    logic [ROOT_W-1:0] c_root  [0:ROOT_W];

    gdg_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .NUM_CLASSES (NUM_CLASSES),
        .DW          (DW),
        .VW          (VW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_frame_start (i_frame_start),
        .i_cell_class  (i_cell_class),
        .o_valid       (c_valid[0]),
        .i_ready       (c_rdy[0]),
        .o_blocked     (c_blk[0]),
        .o_v           (c_v[0])
    );

    assign c_rem[0]  = '0;
    assign c_root[0] = '0;

    // Square root chain, one result bit per cell
    for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
        gdg_root_cell #(
            .ROOT_W (ROOT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (c_valid[k]),
            .o_ready   (c_rdy[k]),
            .i_blocked (c_blk[k]),
            .i_v       (c_v[k]),
            .i_rem     (c_rem[k]),
            .i_root    (c_root[k]),
            .o_valid   (c_valid[k+1]),
            .i_ready   (c_rdy[k+1]),
            .o_blocked (c_blk[k+1]),
            .o_v       (c_v[k+1]),
            .o_rem     (c_rem[k+1]),
            .o_root    (c_root[k+1])
        );
    end

    // Output register with saturation and blocked override
    logic              r_out_valid, r_out_blocked;
    logic [DIST_W-1:0] r_out_dist, n_out_dist;
    logic [ROOT_W-1:0] root;

    assign c_rdy[ROOT_W] = !r_out_valid || i_ready;
    assign root          = c_root[ROOT_W];

    always_comb begin
        if (c_blk[ROOT_W]) begin
            n_out_dist = '0;
        end else if (root > ROOT_W'(DIST_MAX)) begin
            n_out_dist = DIST_MAX;
        end else begin
            n_out_dist = root[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_rdy[ROOT_W]) begin
            r_out_valid <= c_valid[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_valid[ROOT_W] && c_rdy[ROOT_W]) begin
            r_out_blocked <= c_blk[ROOT_W];
            r_out_dist    <= n_out_dist;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_blocked     = r_out_blocked;
    assign o_distance_q4 = r_out_dist;

endmodule

// File: rtl/gdg_front.sv
// Front end: position counters, obstacle test, offsets, squares and scaled sum.
`timescale 1ns / 1ps

module gdg_front
    import gdg_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int NUM_CLASSES = 32,
    parameter int DW          = 10,
    parameter int VW          = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_frame_start,
    input  logic [CLASS_W-1:0] i_cell_class,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_blocked,
    output logic [VW-1:0]      o_v
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int EW  = (CW > RW) ? ((CW > COORD_W) ? CW : COORD_W)
                                   : ((RW > COORD_W) ? RW : COORD_W);
    localparam int WCW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
    localparam int NCW = 7;
    localparam int QW  = 2 * DW;
    localparam int SW  = 2 * DW + 1;

    // Position counters
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // Stage registers
    logic            r0_valid, r0_blocked;
    logic [DW-1:0]   r0_dc, r0_dr;
    logic            r1_valid, r1_blocked;
    logic [2*DW-1:0] r1_sqc, r1_sqr;
    logic            r2_valid, r2_blocked;
    logic [VW-1:0]   r2_v;

    logic            s1_ready, s2_ready, in_xfer;
    logic [CW-1:0]   col;
    logic [RW-1:0]   row;
    logic [WCW-1:0]  width, col_p1;
    logic            in_ego, obstacle, blocked;
    logic [DW-1:0]   dc, dr, gc, gr, cc, rr;
    logic [SW-1:0]   sum_sq;

    // Elastic handshake along the stages
    assign s2_ready = !r2_valid || i_ready;
    assign s1_ready = !r1_valid || s2_ready;
    assign o_ready  = !r0_valid || s1_ready;
    assign in_xfer  = i_valid && o_ready;

    // Cell position and classification
    always_comb begin
        col = i_frame_start ? '0 : r_col;
        row = i_frame_start ? '0 : r_row;
        in_ego = (EW'(col) >= EW'(i_cfg.ego_left)) && (EW'(col) <= EW'(i_cfg.ego_right)) &&
                 (EW'(row) >= EW'(i_cfg.ego_top))  && (EW'(row) <= EW'(i_cfg.ego_bottom));
        obstacle = (NCW'(i_cell_class) < NCW'(NUM_CLASSES)) &&
                   i_cfg.obstacle_class_mask[i_cell_class];
        blocked = !in_ego && obstacle;
        gc = DW'(i_cfg.goal_col);
        gr = DW'(i_cfg.goal_row);
        cc = DW'(col);
        rr = DW'(row);
        dc = (gc >= cc) ? gc - cc : cc - gc;
        dr = (gr >= rr) ? gr - rr : rr - gr;
    end

    // Next position: wrap at the frame width, hold at the last row
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            width = WCW'(1);
        end else if (WCW'(i_cfg.frame_width) > WCW'(MAX_WIDTH)) begin
            width = WCW'(MAX_WIDTH);
        end else begin
            width = WCW'(i_cfg.frame_width);
        end
        col_p1 = WCW'(col) + WCW'(1);
        n_row  = row;
        if (col_p1 >= width) begin
            n_col = '0;
            if (row < RW'(MAX_HEIGHT - 1)) begin
                n_row = row + RW'(1);
            end
        end else begin
            n_col = col_p1[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_xfer) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (o_ready)  r0_valid <= i_valid;
            if (s1_ready) r1_valid <= r0_valid;
            if (s2_ready) r2_valid <= r1_valid;
        end
    end

    assign sum_sq = SW'(r1_sqc) + SW'(r1_sqr);

    // Payload: offsets, squares, scaled sum
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r0_blocked <= blocked;
            r0_dc      <= dc;
            r0_dr      <= dr;
        end
        if (r0_valid && s1_ready) begin
            r1_blocked <= r0_blocked;
            r1_sqc     <= QW'(r0_dc) * QW'(r0_dc);
            r1_sqr     <= QW'(r0_dr) * QW'(r0_dr);
        end
        if (r1_valid && s2_ready) begin
            r2_blocked <= r1_blocked;
            r2_v       <= VW'(sum_sq) << Q_SHIFT;
        end
    end

    assign o_valid   = r2_valid;
    assign o_blocked = r2_blocked;
    assign o_v       = r2_v;

endmodule

// File: rtl/gdg_root_cell.sv
// One cell of the square root chain: settles one root bit per cell.
`timescale 1ns / 1ps

module gdg_root_cell #(
    parameter int ROOT_W = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_blocked,
    input  logic [2*ROOT_W-1:0] i_v,
    input  logic [ROOT_W:0]     i_rem,
    input  logic [ROOT_W-1:0]   i_root,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_blocked,
    output logic [2*ROOT_W-1:0] o_v,
    output logic [ROOT_W:0]     o_rem,
    output logic [ROOT_W-1:0]   o_root
);

    localparam int VW    = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;
    localparam int SH_W  = ROOT_W + 3;

    logic                r_valid, r_blocked;
    logic [VW-1:0]       r_v;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [SH_W-1:0]     sh, trial, diff;
    logic                take;

    assign o_ready = !r_valid || i_ready;

    // Bring down the next bit pair and try the candidate bit
    always_comb begin
        sh     = {i_rem, i_v[VW-1 -: 2]};
        trial  = SH_W'({i_root, 2'b01});
        take   = sh >= trial;
        diff   = sh - trial;
        n_rem  = take ? diff[REM_W-1:0] : sh[REM_W-1:0];
        n_root = {i_root[ROOT_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_blocked <= i_blocked;
            r_v       <= {i_v[VW-3:0], 2'b00};
            r_rem     <= n_rem;
            r_root    <= n_root;
        end
    end

    assign o_valid   = r_valid;
    assign o_blocked = r_blocked;
    assign o_v       = r_v;
    assign o_rem     = r_rem;
    assign o_root    = r_root;

endmodule

// File: rtl/gdg_checker.sv
// Port-level checks for the grid distance-to-goal block, bound to the top level.
`timescale 1ns / 1ps

module gdg_checker
    import gdg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_ready,
    input logic              o_valid,
    input logic [DIST_W-1:0] o_distance_q4,
    input logic              o_blocked
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_distance_q4) && $stable(o_blocked))
        else $error("result payload changed while stalled");

    // Blocked cells carry a zero distance
    a_blocked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_blocked |-> o_distance_q4 == '0)
        else $error("blocked cell with nonzero distance");

    // Reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

endmodule

bind grid_distance_to_goal gdg_checker u_gdg_checker (.*);
